FILE: rtl/positional_array_list_assert.svh
// Assertion macros shared by the list block.
// Each check is sampled on the rising edge of i_clk and is held off while i_rst_n is low.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pal: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PAL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pal: next-cycle check failed");

`endif

FILE: rtl/pal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

    // Operation codes carried by the kind field
    typedef enum logic [1:0] {
        K_GET    = 2'd0,
        K_LOCATE = 2'd1,
        K_INSERT = 2'd2,
        K_DELETE = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_GETR,
        S_GETD,
        S_SCAN,
        S_SHUP,
        S_PUT,
        S_SHDN,
        S_DONE
    } t_state;

    // One result beat
    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic [7:0]         list_count;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/pal_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation per beat
interface pal_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/pal_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Response channel: one result per beat
interface pal_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         list_count;

    modport source (output valid, output status, output read_value,
                    output found_position, output list_count, input ready);
    modport sink   (input valid, input status, input read_value,
                    input found_position, input list_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/positional_array_list.sv
// Positional array list: an ordered list of up to DEPTH signed 32-bit values.
// i_req carries one operation per beat (kind, 1-based position, value):
// get, locate, insert or delete. o_rsp returns exactly one result beat per
// request: status, read_value, found_position and the new list_count.
// The element store has a single read port: the sequencer reads one entry
// a cycle and writes the moved entry back in the cycle after its read, so
// one request is worked at a time.
// The result sits in an output register; a new request is taken as soon as
// the sequencer is idle, even while that result waits on o_rsp.ready.
// If the receiver stalls with a result held and a second one finished, the
// sequencer holds it and takes no new request until the register frees.
// Synchronous active-low reset empties the list; store contents are not
// cleared, and entries past the length are never read.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list
    import pal_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pal_req_if.sink   i_req,
    pal_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);

    logic          res_valid;
    logic          res_ready;
    t_result       res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic          r_out_valid;
    t_result       r_out;

    pal_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    pal_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register: free when empty or draining this cycle
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    // Result beat
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.read_value     = r_out.read_value;
    assign o_rsp.found_position = r_out.found_position;
    assign o_rsp.list_count     = r_out.list_count;

endmodule

`default_nettype wire

FILE: rtl/pal_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/pal_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "positional_array_list_assert.svh"

// Operation sequencer: walks the element store one entry per cycle
module pal_ctrl
    import pal_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    pal_req_if.sink                       i_req,
    output logic                          o_res_valid,
    input  wire logic                     i_res_ready,
    output t_result                       o_res,
    output logic                          o_ram_we,
    output logic [$clog2(DEPTH)-1:0]      o_ram_waddr,
    output logic [31:0]                   o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0]      o_ram_raddr,
    input  wire logic [31:0]              i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > 8) ? CW : 8) + 1;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_lag_idx, n_lag_idx;
    logic               r_lag, n_lag;
    logic [CW-1:0]      r_pm1, n_pm1;
    logic signed [31:0] r_val, n_val;
    t_result            r_res, n_res;

    logic               ram_re;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic               bad_pos;
    logic               bad_ins;
    logic               full;

    // low byte of a count or position
    function automatic logic [7:0] lo8(input logic [CW-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return x[7:0];
    endfunction

    // Position checks against the current length
    assign pos_x   = XW'(i_req.position);
    assign cnt_x   = XW'(r_cnt);
    assign bad_pos = (pos_x == '0) || (pos_x > cnt_x);
    assign bad_ins = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
    assign full    = (r_cnt == CW'(DEPTH));

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_lag   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lag   <= n_lag;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_lag_idx <= n_lag_idx;
        r_pm1     <= n_pm1;
        r_val     <= n_val;
        r_res     <= n_res;
    end

    // Next state, store accesses and result
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_lag       = r_lag;
        n_lag_idx   = r_lag_idx;
        n_pm1       = r_pm1;
        n_val       = r_val;
        n_res       = r_res;
        i_req.ready = 1'b0;
        o_res_valid = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_raddr = '0;
        ram_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_val = i_req.value;
                    n_pm1 = CW'(pos_x - XW'(1));
                    n_lag = 1'b0;
                    n_res = '{status: ST_OK, read_value: '0, found_position: '0,
                              list_count: lo8(r_cnt)};
                    case (t_kind'(i_req.kind))
                        K_GET: begin
                            if (bad_pos) begin
                                n_res.status = ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_GETR;
                            end
                        end
                        K_LOCATE: begin
                            n_idx   = '0;
                            n_state = (r_cnt == '0) ? S_DONE : S_SCAN;
                        end
                        K_INSERT: begin
                            if (bad_ins) begin
                                n_res.status = ST_RANGE;
                                n_state      = S_DONE;
                            end else if (full) begin
                                n_res.status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_idx   = r_cnt;
                                n_state = S_SHUP;
                            end
                        end
                        K_DELETE: begin
                            if (bad_pos) begin
                                n_res.status = ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_idx   = CW'(pos_x - XW'(1));
                                n_state = S_SHDN;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            // get: one read, data back in the cycle after it
            S_GETR: begin
                ram_re      = 1'b1;
                o_ram_raddr = r_pm1[AW-1:0];
                n_state     = S_GETD;
            end

            S_GETD: begin
                n_res.read_value = i_ram_rdata;
                n_state          = S_DONE;
            end

            // locate: issue one read a cycle, compare the one that came back
            S_SCAN: begin
                if (r_lag && (i_ram_rdata == r_val)) begin
                    n_res.found_position = lo8(r_lag_idx + CW'(1));
                    n_lag                = 1'b0;
                    n_state              = S_DONE;
                end else if (r_idx < r_cnt) begin
                    ram_re      = 1'b1;
                    o_ram_raddr = r_idx[AW-1:0];
                    n_lag       = 1'b1;
                    n_lag_idx   = r_idx;
                    n_idx       = r_idx + CW'(1);
                end else begin
                    n_lag   = 1'b0;
                    n_state = S_DONE;
                end
            end

            // insert: move the tail up from the top, read below the write
            S_SHUP: begin
                if (r_lag) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = AW'(r_lag_idx + CW'(1));
                    o_ram_wdata = i_ram_rdata;
                end
                if (r_idx > r_pm1) begin
                    ram_re      = 1'b1;
                    o_ram_raddr = AW'(r_idx - CW'(1));
                    n_lag       = 1'b1;
                    n_lag_idx   = r_idx - CW'(1);
                    n_idx       = r_idx - CW'(1);
                end else begin
                    n_lag = 1'b0;
                    if (!r_lag) begin
                        n_state = S_PUT;
                    end
                end
            end

            S_PUT: begin
                o_ram_we         = 1'b1;
                o_ram_waddr      = r_pm1[AW-1:0];
                o_ram_wdata      = r_val;
                n_cnt            = r_cnt + CW'(1);
                n_res.list_count = lo8(r_cnt + CW'(1));
                n_state          = S_DONE;
            end

            // delete: first read is the removed entry, the rest move down
            S_SHDN: begin
                if (r_lag) begin
                    if (r_lag_idx == r_pm1) begin
                        n_res.read_value = i_ram_rdata;
                    end else begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = AW'(r_lag_idx - CW'(1));
                        o_ram_wdata = i_ram_rdata;
                    end
                end
                if (r_idx < r_cnt) begin
                    ram_re      = 1'b1;
                    o_ram_raddr = r_idx[AW-1:0];
                    n_lag       = 1'b1;
                    n_lag_idx   = r_idx;
                    n_idx       = r_idx + CW'(1);
                end else begin
                    n_lag = 1'b0;
                    if (!r_lag) begin
                        n_cnt            = r_cnt - CW'(1);
                        n_res.list_count = lo8(r_cnt - CW'(1));
                        n_state          = S_DONE;
                    end
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_res = r_res;

    // a read never lands on the entry being written in the same cycle
    `PAL_ASSERT_NOW(a_no_rw_clash, o_ram_we && ram_re, o_ram_waddr != o_ram_raddr)
    // the length only moves at the end of an insert or a delete
    `PAL_ASSERT_NEXT(a_cnt_hold, r_state == S_IDLE || r_state == S_SCAN, r_cnt == $past(r_cnt))
    // a full status is only given with the store at capacity
    `PAL_ASSERT_NOW(a_full_cap, o_res_valid && r_res.status == ST_FULL, r_cnt == CW'(DEPTH))
    // the scan pointer never passes the length
    `PAL_ASSERT_NOW(a_scan_bound, r_state == S_SCAN || r_state == S_SHDN, r_idx <= r_cnt)

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pal_pkg::*;

    localparam int DEPTH      = 128;
    localparam int RAND_ITEMS = 1900;
    localparam int CALM_TAIL  = 200;   // final beats sent with no idling
    localparam int QUIET_MAX  = 4000;  // cycles without any beat before giving up

    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase;

    typedef struct {
        t_kind              k;
        logic [7:0]         p;
        logic signed [31:0] v;
        bit                 typed;
        t_result            want;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pal_req_if req_bus ();
    pal_rsp_if rsp_bus ();

    positional_array_list #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the list, advanced once per accepted request beat
    logic signed [31:0] list_mem [DEPTH];
    int unsigned        list_len;

    t_result     pending [$];
    t_step       script [$];
    bit          failed;
    bit          idle_on;
    int unsigned stall_left;
    int unsigned quiet;

    function automatic t_result apply_op(input t_kind k, input logic [7:0] p,
                                         input logic signed [31:0] v);
        t_result     r;
        int unsigned j;
        r = '0;
        r.status = ST_OK;
        case (k)
            K_GET: begin
                if (p < 1 || p > list_len) r.status = ST_RANGE;
                else r.read_value = list_mem[p - 1];
            end
            K_LOCATE: begin
                // first match wins
                for (j = 0; j < list_len; j++)
                    if (r.found_position == 0 && list_mem[j] == v)
                        r.found_position = 8'(j + 1);
            end
            K_INSERT: begin
                // position is checked before fullness
                if (p < 1 || p > list_len + 1) begin
                    r.status = ST_RANGE;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (j = list_len; j >= p; j--) list_mem[j] = list_mem[j - 1];
                    list_mem[p - 1] = v;
                    list_len++;
                end
            end
            default: begin
                if (p < 1 || p > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = list_mem[p - 1];
                    for (j = p; j < list_len; j++) list_mem[j - 1] = list_mem[j];
                    list_len--;
                end
            end
        endcase
        r.list_count = 8'(list_len);
        return r;
    endfunction

    // Mostly legal positions, some on the edges of the range, some anywhere
    function automatic logic [7:0] pick_position(input t_kind k);
        int unsigned lim;
        int unsigned r;
        lim = (k == K_INSERT) ? list_len + 1 : list_len;
        r = $urandom_range(0, 9);
        if (r < 7 && lim != 0) return 8'($urandom_range(1, lim));
        if (r < 8) begin
            r = $urandom_range(0, 2);
            if (r == 0) return 8'd0;
            if (r == 1) return 8'(lim);
            return 8'(lim + 1);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Locate mostly looks for values held; a small pool gives duplicates
    function automatic logic signed [31:0] pick_value(input t_kind k);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (k == K_LOCATE && list_len != 0 && r < 6)
            return list_mem[$urandom_range(0, list_len - 1)];
        if (r < 4) return $urandom;
        if (r < 7) return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        if (r == 7) return 32'sh8000_0000;
        if (r == 8) return 32'sh7fff_ffff;
        return $urandom;
    endfunction

    task automatic row(input t_kind k, input int p, input logic signed [31:0] v,
                       input bit typed, input t_status st, input logic signed [31:0] rd,
                       input int fp, input int cnt);
        t_step s;
        s.k = k;
        s.p = 8'(p);
        s.v = v;
        s.typed = typed;
        s.want.status = st;
        s.want.read_value = rd;
        s.want.found_position = 8'(fp);
        s.want.list_count = 8'(cnt);
        script.push_back(s);
    endtask

    // Offer one request beat, wait for it to be taken, record what should come back
    task automatic issue(input t_kind k, input logic [7:0] p, input logic signed [31:0] v,
                         input bit typed, input t_result want);
        t_result model;
        req_bus.valid    <= 1'b1;
        req_bus.kind     <= k;
        req_bus.position <= p;
        req_bus.value    <= v;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        model = apply_op(k, p, v);
        pending.push_back(typed ? want : model);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Hold the request side until every outstanding result is back
    task automatic hold_until_drained();
        req_bus.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    // Result side: compare each beat with the oldest expectation, and pace ready
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (rsp_bus.valid && rsp_bus.ready) begin
            got.status         = t_status'(rsp_bus.status);
            got.read_value     = rsp_bus.read_value;
            got.found_position = rsp_bus.found_position;
            got.list_count     = rsp_bus.list_count;
            if (pending.size() == 0) begin
                $display("%0t: result beat with none expected: status=%0d read=%0d found=%0d count=%0d",
                         $time, got.status, got.read_value, got.found_position, got.list_count);
                failed = 1'b1;
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch: expected status=%0d read=%0d found=%0d count=%0d",
                             $time, want.status, want.read_value, want.found_position,
                             want.list_count);
                    $display("%0t:           actual   status=%0d read=%0d found=%0d count=%0d",
                             $time, got.status, got.read_value, got.found_position,
                             got.list_count);
                    failed = 1'b1;
                end
            end
        end
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (!idle_on) begin
            rsp_bus.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // Watchdog: too long with no beat on either channel
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_MAX) begin
            $display("%0t: no beat for %0d cycles", $time, quiet);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_step       s;
        t_phase      phase;
        t_kind       k;
        int unsigned n;
        int unsigned r;
        int unsigned lingering;
        int unsigned in_phase;

        i_rst_n          = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.kind     = K_GET;
        req_bus.position = 8'd0;
        req_bus.value    = 32'sd0;
        rsp_bus.ready    = 1'b0;
        failed           = 1'b0;
        idle_on          = 1'b1;
        stall_left       = 0;
        quiet            = 0;
        list_len         = 0;

        // Directed: empty list, bad positions, extremes, append, duplicates
        row(K_GET,    1,   32'sd0,          1, ST_RANGE, 32'sd0,          0, 0);
        row(K_DELETE, 1,   32'sd0,          1, ST_RANGE, 32'sd0,          0, 0);
        row(K_LOCATE, 0,   32'sh8000_0000,  1, ST_OK,    32'sd0,          0, 0);
        row(K_INSERT, 0,   32'sd5,          1, ST_RANGE, 32'sd0,          0, 0);
        row(K_INSERT, 2,   32'sd5,          1, ST_RANGE, 32'sd0,          0, 0);
        row(K_INSERT, 1,   32'sh8000_0000,  1, ST_OK,    32'sd0,          0, 1);
        row(K_INSERT, 2,   32'sh7fff_ffff,  1, ST_OK,    32'sd0,          0, 2);
        row(K_INSERT, 1,   -32'sd1,         1, ST_OK,    32'sd0,          0, 3);
        row(K_GET,    1,   32'sd0,          1, ST_OK,    -32'sd1,         0, 3);
        row(K_GET,    3,   32'sd0,          1, ST_OK,    32'sh7fff_ffff,  0, 3);
        row(K_GET,    4,   32'sd0,          1, ST_RANGE, 32'sd0,          0, 3);
        row(K_GET,    255, 32'sd0,          1, ST_RANGE, 32'sd0,          0, 3);
        row(K_LOCATE, 0,   32'sh8000_0000,  1, ST_OK,    32'sd0,          2, 3);
        row(K_LOCATE, 0,   32'sd0,          1, ST_OK,    32'sd0,          0, 3);
        row(K_INSERT, 4,   32'sd0,          1, ST_OK,    32'sd0,          0, 4);
        row(K_INSERT, 255, 32'sd1,          1, ST_RANGE, 32'sd0,          0, 4);
        row(K_INSERT, 3,   -32'sd1,         0, ST_OK,    32'sd0,          0, 0);
        row(K_LOCATE, 0,   -32'sd1,         1, ST_OK,    32'sd0,          1, 5);
        row(K_DELETE, 6,   32'sd0,          1, ST_RANGE, 32'sd0,          0, 5);
        row(K_DELETE, 0,   32'sd0,          1, ST_RANGE, 32'sd0,          0, 5);
        row(K_DELETE, 2,   32'sd0,          1, ST_OK,    32'sh8000_0000,  0, 4);
        row(K_DELETE, 4,   32'sd0,          1, ST_OK,    32'sd0,          0, 3);
        row(K_GET,    2,   32'sh7fff_ffff,  0, ST_OK,    32'sd0,          0, 0);
        row(K_LOCATE, 255, 32'sh7fff_ffff,  0, ST_OK,    32'sd0,          0, 0);
        row(K_DELETE, 1,   32'sd0,          0, ST_OK,    32'sd0,          0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            s = script[i];
            issue(s.k, s.p, s.v, s.typed, s.want);
        end
        hold_until_drained();

        // Random: fill to full and beyond, drain to empty and beyond, then a mixed spell
        phase = PH_FILL;
        lingering = 0;
        in_phase = 0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n >= RAND_ITEMS - CALM_TAIL) idle_on = 1'b0;
            r = $urandom_range(0, 99);
            case (phase)
                PH_FILL:  k = (r < 75) ? K_INSERT : (r < 85) ? K_LOCATE :
                              (r < 95) ? K_GET : K_DELETE;
                PH_DRAIN: k = (r < 75) ? K_DELETE : (r < 85) ? K_LOCATE :
                              (r < 95) ? K_GET : K_INSERT;
                default:  k = t_kind'(r % 4);
            endcase
            issue(k, pick_position(k), pick_value(k), 1'b0, '0);
            in_phase++;

            case (phase)
                PH_FILL:  if (list_len == DEPTH) lingering++;
                PH_DRAIN: if (list_len == 0) lingering++;
                default:  lingering = in_phase;
            endcase
            if ((phase == PH_FILL && lingering >= 20) ||
                (phase == PH_DRAIN && lingering >= 10) ||
                (phase == PH_MIXED && lingering >= 150)) begin
                phase = (phase == PH_FILL) ? PH_DRAIN :
                        (phase == PH_DRAIN) ? PH_MIXED : PH_FILL;
                lingering = 0;
                in_phase = 0;
                hold_until_drained();
                idle_on = (n < RAND_ITEMS - CALM_TAIL) && ($urandom_range(0, 2) != 0);
            end
        end

        req_bus.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        // allow for a stray result from the longest shift
        repeat (DEPTH + 16) @(posedge i_clk);

        if (!failed) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
